/* src/pcw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and size helpers of the padded crop window engine.
// Used by pcw_cfg, the top level and the testbench; depends on nothing.
package pcw_pkg;

    localparam int MAX_HEIGHT   = 64;
    localparam int MAX_WIDTH    = 64;
    localparam int MAX_CHANNELS = 4;
    localparam int WORD_WIDTH   = 32;
    localparam int CROP_MAX     = 128;

    localparam int DIM_W   = 7;
    localparam int CHAN_W  = 3;
    localparam int CROP_W  = 8;
    localparam int OFF_W   = 8;
    localparam int POS_W   = 7;
    localparam int SEL_W   = 2;
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int AREA_W  = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
    localparam int PIX_W   = $clog2(MAX_HEIGHT * MAX_WIDTH);
    localparam int DEPTH   = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = 15;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 8;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_IN_HEIGHT      = 4'd0,
        REG_IN_WIDTH       = 4'd1,
        REG_CHANNELS       = 4'd2,
        REG_CROP_HEIGHT    = 4'd3,
        REG_CROP_WIDTH     = 4'd4,
        REG_ROW_OFFSET     = 4'd5,
        REG_COL_OFFSET     = 4'd6,
        REG_CHANNELS_FIRST = 4'd7
    } pcw_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PIX  = 4'b0010,
        ST_ADDR = 4'b0100,
        ST_OUT  = 4'b1000
    } pcw_state_t;

    typedef struct packed {
        logic [DIM_W-1:0]        height;
        logic [DIM_W-1:0]        width;
        logic [CHAN_W-1:0]       chans;
        logic [CROP_W-1:0]       crop_h;
        logic [CROP_W-1:0]       crop_w;
        logic signed [OFF_W-1:0] row_off;
        logic signed [OFF_W-1:0] col_off;
        logic                    chan_first;
        logic [AREA_W-1:0]       area;
    } pcw_cfg_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int hi);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(hi)) r = DIM_W'(hi);
        else r = v;
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] r;
        if (v == '0) r = CHAN_W'(1);
        else if (v > CHAN_W'(MAX_CHANNELS)) r = CHAN_W'(MAX_CHANNELS);
        else r = v;
        return r;
    endfunction

    function automatic logic [CROP_W-1:0] clamp_crop(input logic [CROP_W-1:0] v);
        logic [CROP_W-1:0] r;
        if (v == '0) r = CROP_W'(1);
        else if (v > CROP_W'(CROP_MAX)) r = CROP_W'(CROP_MAX);
        else r = v;
        return r;
    endfunction

endpackage

/* src/pcw_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file of the padded crop window engine.
// Keeps sizes already clamped and the image area; depends on pcw_pkg.
module pcw_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pcw_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pcw_pkg::DATA_W-1:0]   cfg_data,
    output pcw_pkg::pcw_cfg_t            cfg
);

    pcw_pkg::pcw_cfg_t cfg_reg;
    pcw_pkg::pcw_cfg_t cfg_next;
    logic [pcw_pkg::DIM_W-1:0] dim_h;
    logic [pcw_pkg::DIM_W-1:0] dim_w;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign dim_h     = pcw_pkg::clamp_dim(cfg_data[pcw_pkg::DIM_W-1:0], pcw_pkg::MAX_HEIGHT);
    assign dim_w     = pcw_pkg::clamp_dim(cfg_data[pcw_pkg::DIM_W-1:0], pcw_pkg::MAX_WIDTH);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pcw_pkg::REG_IN_HEIGHT:
                begin
                    cfg_next.height = dim_h;
                    cfg_next.area   = pcw_pkg::AREA_W'(dim_h) *
                                      pcw_pkg::AREA_W'(cfg_reg.width);
                end
                pcw_pkg::REG_IN_WIDTH:
                begin
                    cfg_next.width = dim_w;
                    cfg_next.area  = pcw_pkg::AREA_W'(cfg_reg.height) *
                                     pcw_pkg::AREA_W'(dim_w);
                end
                pcw_pkg::REG_CHANNELS:
                    cfg_next.chans = pcw_pkg::clamp_chan(cfg_data[pcw_pkg::CHAN_W-1:0]);
                pcw_pkg::REG_CROP_HEIGHT:
                    cfg_next.crop_h = pcw_pkg::clamp_crop(cfg_data);
                pcw_pkg::REG_CROP_WIDTH:
                    cfg_next.crop_w = pcw_pkg::clamp_crop(cfg_data);
                pcw_pkg::REG_ROW_OFFSET:
                    cfg_next.row_off = $signed(cfg_data);
                pcw_pkg::REG_COL_OFFSET:
                    cfg_next.col_off = $signed(cfg_data);
                pcw_pkg::REG_CHANNELS_FIRST:
                    cfg_next.chan_first = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.height     <= pcw_pkg::DIM_W'(1);
            cfg_reg.width      <= pcw_pkg::DIM_W'(1);
            cfg_reg.chans      <= pcw_pkg::CHAN_W'(1);
            cfg_reg.crop_h     <= pcw_pkg::CROP_W'(1);
            cfg_reg.crop_w     <= pcw_pkg::CROP_W'(1);
            cfg_reg.row_off    <= '0;
            cfg_reg.col_off    <= '0;
            cfg_reg.chan_first <= 1'b1;
            cfg_reg.area       <= pcw_pkg::AREA_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/pcw_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and appears in the cycle after the read enable; depends on nothing.
module pcw_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

/* src/padded_crop_window_engine.sv */
`timescale 1ns / 1ps
// Top level of the padded crop window engine: transfer sequencer, counters and
// address generation around the image RAM; depends on pcw_pkg, pcw_cfg, pcw_ram.
//
// A load transfer (opcode 0) writes the next image word into the RAM; the
// image is complete after height times width times channels loads. A fetch
// transfer (opcode 1) steps through the accepted transfer, a state for the row
// product, a state for the channel product and the RAM read, and a state that
// places the word in the output register once that register is free; no new
// transfer is taken until the fetch is done. Loads are taken while a result
// waits in the output register. Words outside the image read as zero, fetches
// before the image is complete and loads after it are dropped, and the word
// marked last ends the job so the next image can be loaded.
module padded_crop_window_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 opcode,
    input  logic [pcw_pkg::WORD_WIDTH-1:0]       pixel_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pcw_pkg::WORD_WIDTH-1:0]       pixel_out,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcw_pkg::IDX_W-1:0]            cfg_index,
    input  logic [pcw_pkg::DATA_W-1:0]           cfg_data
);

    pcw_pkg::pcw_cfg_t   cfg;
    pcw_pkg::pcw_state_t state_reg, state_next;

    logic [pcw_pkg::COUNT_W-1:0] load_count_reg, load_count_next;
    logic                        loaded_reg, loaded_next;
    logic [pcw_pkg::POS_W-1:0]   out_row_reg, out_row_next;
    logic [pcw_pkg::POS_W-1:0]   out_col_reg, out_col_next;
    logic [pcw_pkg::SEL_W-1:0]   out_chan_reg, out_chan_next;
    logic                        out_valid_reg, out_valid_next;

    logic [pcw_pkg::ROW_W-1:0]      y_reg;
    logic [pcw_pkg::COL_W-1:0]      x_reg;
    logic [pcw_pkg::SEL_W-1:0]      chan_reg;
    logic                           in_range_reg;
    logic                           is_last_reg;
    logic [pcw_pkg::PIX_W-1:0]      pix_reg;
    logic [pcw_pkg::WORD_WIDTH-1:0] pixel_out_reg;
    logic                           last_reg;

    logic                              accept;
    logic                              fetch_go;
    logic                              ram_we;
    logic                              ram_re;
    logic [pcw_pkg::ADDR_W-1:0]        ram_raddr;
    logic [pcw_pkg::WORD_WIDTH-1:0]    ram_rdata;
    logic [pcw_pkg::COUNT_W-1:0]       total;
    logic [pcw_pkg::COUNT_W-1:0]       count_inc;
    logic signed [pcw_pkg::OFF_W:0]    iy;
    logic signed [pcw_pkg::OFF_W:0]    ix;
    logic                              in_range;
    logic                              col_end;
    logic                              row_end;
    logic                              chan_end;
    logic                              is_last;
    logic [pcw_pkg::AREA_W-1:0]        pix_full;
    logic                              out_free;

    pcw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcw_ram #(
        .DEPTH (pcw_pkg::DEPTH),
        .WIDTH (pcw_pkg::WORD_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_count_reg[pcw_pkg::ADDR_W-1:0]),
        .wdata (pixel_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == pcw_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign fetch_go  = accept && (opcode == pcw_pkg::OP_FETCH) && loaded_reg;
    assign ram_we    = accept && (opcode == pcw_pkg::OP_LOAD) && !loaded_reg &&
                       (load_count_reg < pcw_pkg::COUNT_W'(pcw_pkg::DEPTH));
    assign ram_re    = (state_reg == pcw_pkg::ST_ADDR);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign last      = last_reg;

    assign total     = pcw_pkg::COUNT_W'(cfg.area) * pcw_pkg::COUNT_W'(cfg.chans);
    assign count_inc = load_count_reg + pcw_pkg::COUNT_W'(1);

    assign iy = $signed({cfg.row_off[pcw_pkg::OFF_W-1], cfg.row_off}) +
                $signed({2'b00, out_row_reg});
    assign ix = $signed({cfg.col_off[pcw_pkg::OFF_W-1], cfg.col_off}) +
                $signed({2'b00, out_col_reg});
    assign in_range = !iy[pcw_pkg::OFF_W] && !ix[pcw_pkg::OFF_W] &&
                      (iy[pcw_pkg::OFF_W-1:0] < {1'b0, cfg.height}) &&
                      (ix[pcw_pkg::OFF_W-1:0] < {1'b0, cfg.width}) &&
                      ({1'b0, out_chan_reg} < cfg.chans);

    assign col_end  = ({1'b0, out_col_reg} + pcw_pkg::CROP_W'(1)) >= cfg.crop_w;
    assign row_end  = ({1'b0, out_row_reg} + pcw_pkg::CROP_W'(1)) >= cfg.crop_h;
    assign chan_end = ({1'b0, out_chan_reg} + pcw_pkg::CHAN_W'(1)) >= cfg.chans;
    assign is_last  = col_end && row_end && chan_end;

    assign pix_full = pcw_pkg::AREA_W'(y_reg) * pcw_pkg::AREA_W'(cfg.width) +
                      pcw_pkg::AREA_W'(x_reg);

    always_comb
    begin
        if (cfg.chan_first)
        begin
            ram_raddr = pcw_pkg::ADDR_W'(chan_reg) * pcw_pkg::ADDR_W'(cfg.area) +
                        pcw_pkg::ADDR_W'(pix_reg);
        end
        else
        begin
            ram_raddr = pcw_pkg::ADDR_W'(pix_reg) * pcw_pkg::ADDR_W'(cfg.chans) +
                        pcw_pkg::ADDR_W'(chan_reg);
        end
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        loaded_next     = loaded_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_chan_next   = out_chan_reg;

        if (accept && (opcode == pcw_pkg::OP_LOAD) && !loaded_reg)
        begin
            load_count_next = count_inc;
            if (count_inc >= total)
            begin
                loaded_next = 1'b1;
            end
        end

        if (fetch_go)
        begin
            if (cfg.chan_first)
            begin
                if (!col_end)
                begin
                    out_col_next = out_col_reg + pcw_pkg::POS_W'(1);
                end
                else
                begin
                    out_col_next = '0;
                    if (!row_end)
                    begin
                        out_row_next = out_row_reg + pcw_pkg::POS_W'(1);
                    end
                    else
                    begin
                        out_row_next  = '0;
                        out_chan_next = chan_end ? '0 : out_chan_reg + pcw_pkg::SEL_W'(1);
                    end
                end
            end
            else
            begin
                if (!chan_end)
                begin
                    out_chan_next = out_chan_reg + pcw_pkg::SEL_W'(1);
                end
                else
                begin
                    out_chan_next = '0;
                    if (!col_end)
                    begin
                        out_col_next = out_col_reg + pcw_pkg::POS_W'(1);
                    end
                    else
                    begin
                        out_col_next = '0;
                        out_row_next = row_end ? '0 : out_row_reg + pcw_pkg::POS_W'(1);
                    end
                end
            end

            if (is_last)
            begin
                out_row_next    = '0;
                out_col_next    = '0;
                out_chan_next   = '0;
                load_count_next = '0;
                loaded_next     = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            pcw_pkg::ST_IDLE:
                if (fetch_go)
                begin
                    state_next = pcw_pkg::ST_PIX;
                end
            pcw_pkg::ST_PIX:
                state_next = pcw_pkg::ST_ADDR;
            pcw_pkg::ST_ADDR:
                state_next = pcw_pkg::ST_OUT;
            pcw_pkg::ST_OUT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = pcw_pkg::ST_IDLE;
                end
            default:
                state_next = pcw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcw_pkg::ST_IDLE;
            load_count_reg <= '0;
            loaded_reg     <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_chan_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            loaded_reg     <= loaded_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_chan_reg   <= out_chan_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_go)
        begin
            y_reg        <= iy[pcw_pkg::ROW_W-1:0];
            x_reg        <= ix[pcw_pkg::COL_W-1:0];
            chan_reg     <= out_chan_reg;
            in_range_reg <= in_range;
            is_last_reg  <= is_last;
        end
        if (state_reg == pcw_pkg::ST_PIX)
        begin
            pix_reg <= pix_full[pcw_pkg::PIX_W-1:0];
        end
        if ((state_reg == pcw_pkg::ST_OUT) && out_free)
        begin
            pixel_out_reg <= in_range_reg ? ram_rdata : '0;
            last_reg      <= is_last_reg;
        end
    end

`ifndef SYNTHESIS
    a_fetch_starts: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_go |=> (state_reg == pcw_pkg::ST_PIX))
        else $error("accepted fetch did not start address generation");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == pcw_pkg::ST_IDLE) && !loaded_reg))
        else $error("image write outside of the load phase");

    a_counters_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !loaded_reg |-> ((out_row_reg == '0) && (out_col_reg == '0) &&
                         (out_chan_reg == '0)))
        else $error("window counters moved without a complete image");

    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == pcw_pkg::ST_OUT) && out_free) |=> out_valid_reg)
        else $error("finished fetch did not reach the output register");
`endif

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of padded_crop_window_engine: loads images, fetches cropped windows
// and checks every output word against a built-in prediction. Depends on pcw_pkg and the RTL.
module tb;

    localparam int NUM_REGS      = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 250;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [pcw_pkg::WORD_WIDTH-1:0] word;
        logic                           last;
    } crop_word_t;

    class window_scoreboard;
        logic [pcw_pkg::WORD_WIDTH-1:0] image_mem [pcw_pkg::DEPTH];
        logic [pcw_pkg::DATA_W-1:0]     cfg_regs [NUM_REGS];
        int                             load_count;
        bit                             loaded;
        int                             row_pos;
        int                             col_pos;
        int                             chan_pos;
        crop_word_t                     pending_words [$];
        int                             errors;
        int                             words_checked;
        int                             windows_done;

        function new();
            cfg_regs[pcw_pkg::REG_IN_HEIGHT]      = 8'd1;
            cfg_regs[pcw_pkg::REG_IN_WIDTH]       = 8'd1;
            cfg_regs[pcw_pkg::REG_CHANNELS]       = 8'd1;
            cfg_regs[pcw_pkg::REG_CROP_HEIGHT]    = 8'd1;
            cfg_regs[pcw_pkg::REG_CROP_WIDTH]     = 8'd1;
            cfg_regs[pcw_pkg::REG_ROW_OFFSET]     = 8'd0;
            cfg_regs[pcw_pkg::REG_COL_OFFSET]     = 8'd0;
            cfg_regs[pcw_pkg::REG_CHANNELS_FIRST] = 8'd1;
            load_count    = 0;
            loaded        = 1'b0;
            row_pos       = 0;
            col_pos       = 0;
            chan_pos      = 0;
            errors        = 0;
            words_checked = 0;
            windows_done  = 0;
        endfunction

        function int sat_size(logic [pcw_pkg::DATA_W-1:0] v, int hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return int'(v);
        endfunction

        function void write_reg(logic [pcw_pkg::IDX_W-1:0] idx,
                                logic [pcw_pkg::DATA_W-1:0] data);
            unique case (idx) inside
                pcw_pkg::REG_IN_HEIGHT, pcw_pkg::REG_IN_WIDTH:
                    cfg_regs[idx] = data & 8'h7F;
                pcw_pkg::REG_CHANNELS:
                    cfg_regs[idx] = data & 8'h07;
                pcw_pkg::REG_CHANNELS_FIRST:
                    cfg_regs[idx] = data & 8'h01;
                pcw_pkg::REG_CROP_HEIGHT, pcw_pkg::REG_CROP_WIDTH,
                pcw_pkg::REG_ROW_OFFSET, pcw_pkg::REG_COL_OFFSET:
                    cfg_regs[idx] = data;
                default: ;
            endcase
        endfunction

        // Returns 1 when the item changes state, 0 when the block drops it.
        function bit take_item(bit op, logic [pcw_pkg::WORD_WIDTH-1:0] pix);
            int         h;
            int         w;
            int         c;
            int         win_h;
            int         win_w;
            int         row_off;
            int         col_off;
            int         src_row;
            int         src_col;
            int         addr;
            bit         chan_major;
            bit         col_end;
            bit         row_end;
            bit         chan_end;
            crop_word_t want;
            h          = sat_size(cfg_regs[pcw_pkg::REG_IN_HEIGHT], pcw_pkg::MAX_HEIGHT);
            w          = sat_size(cfg_regs[pcw_pkg::REG_IN_WIDTH], pcw_pkg::MAX_WIDTH);
            c          = sat_size(cfg_regs[pcw_pkg::REG_CHANNELS], pcw_pkg::MAX_CHANNELS);
            win_h      = sat_size(cfg_regs[pcw_pkg::REG_CROP_HEIGHT], pcw_pkg::CROP_MAX);
            win_w      = sat_size(cfg_regs[pcw_pkg::REG_CROP_WIDTH], pcw_pkg::CROP_MAX);
            row_off    = int'($signed(cfg_regs[pcw_pkg::REG_ROW_OFFSET]));
            col_off    = int'($signed(cfg_regs[pcw_pkg::REG_COL_OFFSET]));
            chan_major = cfg_regs[pcw_pkg::REG_CHANNELS_FIRST][0];
            if (op == pcw_pkg::OP_LOAD)
            begin
                if (loaded) return 1'b0;
                if (load_count < pcw_pkg::DEPTH) image_mem[load_count] = pix;
                load_count++;
                if (load_count >= h * w * c) loaded = 1'b1;
                return 1'b1;
            end
            if (!loaded) return 1'b0;
            src_row   = row_off + row_pos;
            src_col   = col_off + col_pos;
            want.word = '0;
            if (src_row >= 0 && src_row < h && src_col >= 0 && src_col < w && chan_pos < c)
            begin
                if (chan_major)
                    addr = chan_pos * h * w + src_row * w + src_col;
                else
                    addr = (src_row * w + src_col) * c + chan_pos;
                if (addr < pcw_pkg::DEPTH) want.word = image_mem[addr];
            end
            col_end   = col_pos + 1 >= win_w;
            row_end   = row_pos + 1 >= win_h;
            chan_end  = chan_pos + 1 >= c;
            want.last = col_end && row_end && chan_end;
            if (chan_major)
            begin
                if (!col_end) col_pos++;
                else
                begin
                    col_pos = 0;
                    if (!row_end) row_pos++;
                    else
                    begin
                        row_pos  = 0;
                        chan_pos = chan_end ? 0 : chan_pos + 1;
                    end
                end
            end
            else
            begin
                if (!chan_end) chan_pos++;
                else
                begin
                    chan_pos = 0;
                    if (!col_end) col_pos++;
                    else
                    begin
                        col_pos = 0;
                        row_pos = row_end ? 0 : row_pos + 1;
                    end
                end
            end
            if (want.last)
            begin
                row_pos    = 0;
                col_pos    = 0;
                chan_pos   = 0;
                load_count = 0;
                loaded     = 1'b0;
                windows_done++;
            end
            pending_words.push_back(want);
            return 1'b1;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_word(logic [pcw_pkg::WORD_WIDTH-1:0] word, logic last_flag);
            crop_word_t want;
            if (pending_words.size() == 0)
            begin
                report($sformatf("output word %h last %b with nothing pending",
                                 word, last_flag));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (word !== want.word)
                report($sformatf("pixel_out %h, predicted %h", word, want.word));
            if (last_flag !== want.last)
                report($sformatf("last %b, predicted %b", last_flag, want.last));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           opcode;
    logic [pcw_pkg::WORD_WIDTH-1:0] pixel_in;
    logic                           out_valid;
    logic                           out_ready;
    logic [pcw_pkg::WORD_WIDTH-1:0] pixel_out;
    logic                           last;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [pcw_pkg::IDX_W-1:0]      cfg_index;
    logic [pcw_pkg::DATA_W-1:0]     cfg_data;

    window_scoreboard sb = new();

    bit in_gaps_on;
    bit out_stalls_on;
    int hold_request;
    int items_sent;
    int useful_items;
    int cfg_writes;

    padded_crop_window_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [pcw_pkg::WORD_WIDTH-1:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return pcw_pkg::WORD_WIDTH'($urandom);
    endfunction

    function automatic int rand_dim();
        return ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
    endfunction

    function automatic int rand_offset(int dim, int win);
        int d;
        int v;
        d = (dim == 0) ? 1 : dim;
        v = (win == 0) ? 1 : win;
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, d + v + 2) - v - 1;
    endfunction

    task automatic send_item(input bit op, input logic [pcw_pkg::WORD_WIDTH-1:0] pix);
        int gap;
        in_valid <= 1'b1;
        opcode   <= op;
        pixel_in <= pix;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (sb.take_item(op, pix)) useful_items++;
        gap = in_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [pcw_pkg::IDX_W-1:0] idx,
                             input logic [pcw_pkg::DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Unused upper bits of the narrow registers carry random values.
    task automatic set_config(input int h, input int w, input int c, input int win_h,
                              input int win_w, input int row_off, input int col_off,
                              input int chan_major);
        settle();
        write_reg(pcw_pkg::REG_IN_HEIGHT, {1'($urandom), 7'(h)});
        write_reg(pcw_pkg::REG_IN_WIDTH, {1'($urandom), 7'(w)});
        write_reg(pcw_pkg::REG_CHANNELS, {5'($urandom), 3'(c)});
        write_reg(pcw_pkg::REG_CROP_HEIGHT, 8'(win_h));
        write_reg(pcw_pkg::REG_CROP_WIDTH, 8'(win_w));
        write_reg(pcw_pkg::REG_ROW_OFFSET, 8'(row_off));
        write_reg(pcw_pkg::REG_COL_OFFSET, 8'(col_off));
        write_reg(pcw_pkg::REG_CHANNELS_FIRST, {7'($urandom), 1'(chan_major)});
    endtask

    // One image load and window readout, with optional dropped items and a
    // register change in each half.
    task automatic run_job(input int noise_pct, input bit mid_change, input bit pressure);
        int  n;
        int  split;
        bit  saved_gaps;
        split      = $urandom_range(1, 8);
        saved_gaps = in_gaps_on;
        n          = 0;
        while (!sb.loaded)
        begin
            if ($urandom_range(0, 99) < noise_pct) send_item(pcw_pkg::OP_FETCH, rand_word());
            else send_item(pcw_pkg::OP_LOAD, rand_word());
            n++;
            if (mid_change && n == split && !sb.loaded)
            begin
                settle();
                case ($urandom_range(0, 2))
                    0: write_reg(pcw_pkg::REG_IN_HEIGHT,
                                 pcw_pkg::DATA_W'($urandom_range(0, 6)));
                    1: write_reg(pcw_pkg::REG_IN_WIDTH,
                                 pcw_pkg::DATA_W'($urandom_range(0, 6)));
                    default: write_reg(pcw_pkg::REG_CHANNELS,
                                       pcw_pkg::DATA_W'($urandom_range(0, 6)));
                endcase
            end
        end
        if (pressure)
        begin
            in_gaps_on   = 1'b0;
            hold_request = HOLD_CYCLES;
        end
        n = 0;
        while (sb.loaded)
        begin
            if ($urandom_range(0, 99) < noise_pct) send_item(pcw_pkg::OP_LOAD, rand_word());
            else send_item(pcw_pkg::OP_FETCH, rand_word());
            n++;
            if (mid_change && n == split && sb.loaded)
            begin
                settle();
                case ($urandom_range(0, 4))
                    0: write_reg(pcw_pkg::REG_CROP_HEIGHT,
                                 pcw_pkg::DATA_W'($urandom_range(1, 6)));
                    1: write_reg(pcw_pkg::REG_CROP_WIDTH,
                                 pcw_pkg::DATA_W'($urandom_range(1, 6)));
                    2: write_reg(pcw_pkg::REG_ROW_OFFSET,
                                 pcw_pkg::DATA_W'($urandom_range(0, 6) - 3));
                    3: write_reg(pcw_pkg::REG_CHANNELS_FIRST,
                                 pcw_pkg::DATA_W'($urandom_range(0, 1)));
                    default: write_reg(pcw_pkg::REG_IN_WIDTH,
                                       pcw_pkg::DATA_W'($urandom_range(0, 1)));
                endcase
            end
        end
        in_gaps_on = saved_gaps;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_word(pixel_out, last);
    end

    initial
    begin
        int n;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                n            = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (!out_stalls_on || $urandom_range(0, 99) < 65)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        int base;
        int h;
        int w;
        int win_h;
        int win_w;
        in_valid  <= 1'b0;
        opcode    <= pcw_pkg::OP_LOAD;
        pixel_in  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= pcw_pkg::REG_IN_HEIGHT;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        hold_request  = 0;
        items_sent    = 0;
        useful_items  = 0;
        cfg_writes    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: early fetch dropped, one-word image, extra load dropped.
        send_item(pcw_pkg::OP_FETCH, rand_word());
        send_item(pcw_pkg::OP_LOAD, '1);
        send_item(pcw_pkg::OP_LOAD, '0);
        send_item(pcw_pkg::OP_FETCH, rand_word());

        // Zero sizes act as one; the window starts one column left of the image.
        settle();
        write_reg(pcw_pkg::IDX_W'(NUM_REGS + $urandom_range(0, 7)),
                  pcw_pkg::DATA_W'($urandom));
        set_config(0, 2, 0, 0, 3, 0, -1, 0);
        send_item(pcw_pkg::OP_LOAD, '0);
        send_item(pcw_pkg::OP_LOAD, 32'h8000_0001);
        repeat (3) send_item(pcw_pkg::OP_FETCH, rand_word());

        // Sizes and window changed part way through the load and the readout.
        set_config(1, 4, 2, 2, 2, -1, 2, 1);
        repeat (3) send_item(pcw_pkg::OP_LOAD, rand_word());
        settle();
        write_reg(pcw_pkg::REG_CHANNELS, 8'd1);
        send_item(pcw_pkg::OP_LOAD, rand_word());
        repeat (2) send_item(pcw_pkg::OP_FETCH, rand_word());
        settle();
        write_reg(pcw_pkg::REG_COL_OFFSET, 8'd1);
        write_reg(pcw_pkg::REG_CROP_WIDTH, 8'd1);
        while (sb.loaded) send_item(pcw_pkg::OP_FETCH, rand_word());

        // Saturated sizes, extreme offsets, and a long output stall.
        set_config(127, 1, 1, 200, 1, -64, 0, 1);
        run_job(5, 1'b0, 1'b1);
        set_config(1, 127, 1, 0, 255, 0, -64, 0);
        run_job(5, 1'b0, 1'b0);
        set_config(2, 2, 7, 1, 2, -128, 127, 1);
        run_job(5, 1'b0, 1'b0);
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        set_config(3, 4, 4, 2, 3, 1, 2, 0);
        run_job(0, 1'b0, 1'b0);

        base = useful_items;
        while (useful_items - base < RANDOM_ITEMS)
        begin
            in_gaps_on    = $urandom_range(0, 3) != 0;
            out_stalls_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 19) == 0)
            begin
                settle();
                write_reg(pcw_pkg::IDX_W'(NUM_REGS + $urandom_range(0, 7)),
                          pcw_pkg::DATA_W'($urandom));
            end
            h     = rand_dim();
            w     = rand_dim();
            win_h = ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 6);
            win_w = ($urandom_range(0, 24) == 0) ? 0 : $urandom_range(1, 6);
            set_config(h, w, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) :
                       $urandom_range(0, 4), win_h, win_w, rand_offset(h, win_h),
                       rand_offset(w, win_w), $urandom_range(0, 1));
            run_job(10, $urandom_range(0, 99) < 15, $urandom_range(0, 29) == 0);
        end

        settle();
        $display("Run covered %0d register writes and %0d input transfers, %0d acted on.",
                 cfg_writes, items_sent, useful_items);
        $display("Checked %0d window words over %0d complete windows.",
                 sb.words_checked, sb.windows_done);
        if (sb.errors == 0)
            $display("** padded_crop_window_engine: PASSED **");
        else
            $display("** padded_crop_window_engine: FAILED **");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Run stopped by the time limit with %0d words still pending.",
                 sb.pending_words.size());
        $display("** padded_crop_window_engine: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
src/pcw_pkg.sv
src/pcw_cfg.sv
src/pcw_ram.sv
src/padded_crop_window_engine.sv
bench/tb.sv
